// ===== rtl/rtttl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTTTL parser package
// Item types, character codes, reset values and the note frequency table.
// ----------------------------------------------------------------------------
package rtttl_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [11:0] freq_hz;
        logic [18:0] dur_ms;
        logic        is_rest;
        logic        bad;
    } t_out_item;

    // characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_KEY_D = 8'h64;
    localparam logic [7:0] CH_KEY_O = 8'h6F;
    localparam logic [7:0] CH_KEY_B = 8'h62;

    // reset values and fixed numbers
    localparam logic [15:0] DLEN_RST   = 16'd4;
    localparam logic [2:0]  DOCT_RST   = 3'd6;
    localparam logic [3:0]  OCT_NONE   = 4'd15;
    localparam logic [15:0] ACC_MAX    = 16'hFFFF;
    localparam logic [17:0] WHOLE_DFLT = 18'd3808;   // (60000 / 63) * 4
    localparam logic [17:0] BPM_NUM    = 18'd60000;
    localparam logic [7:0]  IDX_BASE   = 8'd48;
    localparam logic [7:0]  IDX_TOP    = 8'd96;

    // decimal digit push with saturation
    function automatic logic [15:0] acc_push(input logic [15:0] a, input logic [3:0] d);
        logic [19:0] v;
        v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {16'd0, d};
        return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[15:0];
    endfunction

    function automatic logic [3:0] letter_step(input logic [7:0] c);
        logic [3:0] s;
        case (c)
            8'h63:   s = 4'd1;   // c
            8'h64:   s = 4'd3;   // d
            8'h65:   s = 4'd5;   // e
            8'h66:   s = 4'd6;   // f
            8'h67:   s = 4'd8;   // g
            8'h61:   s = 4'd10;  // a
            8'h62:   s = 4'd12;  // b
            default: s = 4'd0;   // p and anything else: rest
        endcase
        return s;
    endfunction

    function automatic logic [11:0] freq_lookup(input logic [5:0] idx);
        logic [11:0] f;
        case (idx)
            6'd1:  f = 12'd262;  6'd2:  f = 12'd277;  6'd3:  f = 12'd294;
            6'd4:  f = 12'd311;  6'd5:  f = 12'd330;  6'd6:  f = 12'd349;
            6'd7:  f = 12'd370;  6'd8:  f = 12'd392;  6'd9:  f = 12'd415;
            6'd10: f = 12'd440;  6'd11: f = 12'd466;  6'd12: f = 12'd494;
            6'd13: f = 12'd523;  6'd14: f = 12'd554;  6'd15: f = 12'd587;
            6'd16: f = 12'd622;  6'd17: f = 12'd659;  6'd18: f = 12'd698;
            6'd19: f = 12'd740;  6'd20: f = 12'd784;  6'd21: f = 12'd831;
            6'd22: f = 12'd880;  6'd23: f = 12'd932;  6'd24: f = 12'd988;
            6'd25: f = 12'd1047; 6'd26: f = 12'd1109; 6'd27: f = 12'd1175;
            6'd28: f = 12'd1245; 6'd29: f = 12'd1319; 6'd30: f = 12'd1397;
            6'd31: f = 12'd1480; 6'd32: f = 12'd1568; 6'd33: f = 12'd1661;
            6'd34: f = 12'd1760; 6'd35: f = 12'd1865; 6'd36: f = 12'd1976;
            6'd37: f = 12'd2093; 6'd38: f = 12'd2217; 6'd39: f = 12'd2349;
            6'd40: f = 12'd2489; 6'd41: f = 12'd2637; 6'd42: f = 12'd2794;
            6'd43: f = 12'd2960; 6'd44: f = 12'd3136; 6'd45: f = 12'd3322;
            6'd46: f = 12'd3520; 6'd47: f = 12'd3729; 6'd48: f = 12'd3951;
            default: f = 12'd0;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rtttl_note_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTTTL note parser
// Character-at-a-time ringtone parser with one shared restoring divider.
// ----------------------------------------------------------------------------
// One character item is taken per accept. Name, header and most note
// characters finish in the accept cycle. A character that closes a note
// (a comma, or the last character inside a note) runs an 18-step
// restoring divide of the whole-note time and then a finishing state
// that writes the note to the output register, and the input stalls
// until it has. A note at zero bpm skips the divide and goes straight
// to the finishing state. The character that ends the b= number runs
// the same divider for 60000/bpm; if it is also the last character the
// note divide follows. Both divides share the one subtract-compare unit.
// A finished note waits in the output register; the next item is still
// taken unless another note is ready before that one has gone.
module rtttl_note_parser_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  rtttl_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  wire                  i_stall,
    output rtttl_pkg::t_out_item o_res
);
    import rtttl_pkg::*;

    typedef enum logic [3:0] {
        PH_NAME   = 4'd0,
        PH_KEY    = 4'd1,
        PH_DEQ    = 4'd2,
        PH_DNUM   = 4'd3,
        PH_OEQ    = 4'd4,
        PH_ODIG   = 4'd5,
        PH_OSKIP  = 4'd6,
        PH_BEQ    = 4'd7,
        PH_BNUM   = 4'd8,
        PH_NDUR   = 4'd9,
        PH_NSHARP = 4'd10,
        PH_NDOT   = 4'd11,
        PH_NOCT   = 4'd12,
        PH_NEND   = 4'd13
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_FIN  = 2'd2
    } t_seq;

    localparam logic [4:0] DIV_LAST = 5'd17;   // 18 quotient bits

    // parser state
    t_phase      r_phase, n_phase;
    logic [15:0] r_dlen, n_dlen;
    logic [2:0]  r_doct, n_doct;
    logic [17:0] r_whole, n_whole;
    logic [15:0] r_acc, n_acc;
    logic [3:0]  r_pitch, n_pitch;
    logic        r_dot, n_dot;
    logic [3:0]  r_oct, n_oct;
    logic        r_bz, n_bz;

    // sequencer and divider
    t_seq        r_seq, n_seq;
    logic        r_job_bpm, n_job_bpm;
    logic        r_pend_emit, n_pend_emit;
    logic        r_pend_last, n_pend_last;
    logic [4:0]  r_cnt, n_cnt;
    logic [17:0] r_dq, n_dq;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_dsr, n_dsr;

    // captured note
    logic [11:0] r_e_freq, n_e_freq;
    logic        r_e_bad, n_e_bad;
    logic        r_e_rest, n_e_rest;
    logic        r_e_skip, n_e_skip;
    logic [15:0] r_e_div, n_e_div;
    logic        r_dot_snap, n_dot_snap;

    // output register
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    // parse scratch
    logic [7:0]  c;
    logic        is_dig;
    logic        key_start, emit_c, emit_l, need_bdiv, do_reset;
    t_phase      v_phase;
    logic [15:0] v_dlen, v_acc, b_dsr, s_acc, e_div;
    logic [2:0]  v_doct;
    logic [17:0] v_whole;
    logic [3:0]  v_pitch, v_oct, s_pitch, s_oct, scale;
    logic        v_dot, v_bz, s_dot, bad0, range_bad;
    logic [7:0]  sum, idx;
    // divider scratch
    logic [16:0] t_part, t_diff;
    logic        ge;
    logic [17:0] q_new;

    assign o_stall = (r_seq != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_comb begin
        n_phase = r_phase; n_dlen = r_dlen; n_doct = r_doct; n_whole = r_whole;
        n_acc = r_acc; n_pitch = r_pitch; n_dot = r_dot; n_oct = r_oct; n_bz = r_bz;
        n_seq = r_seq; n_job_bpm = r_job_bpm; n_pend_emit = r_pend_emit;
        n_pend_last = r_pend_last; n_cnt = r_cnt; n_dq = r_dq; n_rem = r_rem;
        n_dsr = r_dsr;
        n_e_freq = r_e_freq; n_e_bad = r_e_bad; n_e_rest = r_e_rest;
        n_e_skip = r_e_skip; n_e_div = r_e_div; n_dot_snap = r_dot_snap;
        n_out_valid = r_out_valid; n_out = r_out;
        do_reset = 1'b0;

        c      = i_item.ch;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);

        v_phase = r_phase; v_dlen = r_dlen; v_doct = r_doct; v_whole = r_whole;
        v_acc = r_acc; v_pitch = r_pitch; v_dot = r_dot; v_oct = r_oct; v_bz = r_bz;
        key_start = 1'b0; emit_c = 1'b0; emit_l = 1'b0; need_bdiv = 1'b0;
        b_dsr = r_acc;
        s_acc = r_acc; s_pitch = r_pitch; s_dot = r_dot; s_oct = r_oct;
        e_div = r_dlen; bad0 = 1'b0; scale = 4'd0; sum = 8'd0; idx = 8'd0;
        range_bad = 1'b0;

        // divider step
        t_part = {r_rem, r_dq[17]};
        t_diff = t_part - {1'b0, r_dsr};
        ge     = (t_part >= {1'b0, r_dsr});
        q_new  = {r_dq[16:0], ge};

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_seq)
            S_IDLE: begin
                if (i_valid) begin
                    if (r_phase == PH_KEY) begin
                        if (c == CH_KEY_D) begin
                            v_phase = PH_DEQ;
                        end else if (c == CH_KEY_O) begin
                            v_phase = PH_OEQ;
                        end else if (c == CH_KEY_B) begin
                            v_phase = PH_BEQ;
                        end else begin
                            // no key: notes start with current settings
                            v_whole = WHOLE_DFLT; v_bz = 1'b0;
                            v_acc = 16'd0; v_pitch = 4'd0; v_dot = 1'b0;
                            v_oct = OCT_NONE;
                            v_phase = PH_NDUR;
                            key_start = 1'b1;
                        end
                    end

                    if (r_phase != PH_KEY || key_start) begin
                        case (v_phase)
                            PH_DEQ: begin
                                v_acc = 16'd0; v_phase = PH_DNUM;
                            end
                            PH_DNUM: begin
                                if (is_dig) begin
                                    v_acc = acc_push(v_acc, c[3:0]);
                                end else begin
                                    if (v_acc != 16'd0) v_dlen = v_acc;
                                    v_acc = 16'd0; v_phase = PH_KEY;
                                end
                            end
                            PH_OEQ:   v_phase = PH_ODIG;
                            PH_ODIG: begin
                                if (c >= CH_THREE && c <= CH_SEVEN) v_doct = c[2:0];
                                v_phase = PH_OSKIP;
                            end
                            PH_OSKIP: v_phase = PH_KEY;
                            PH_BEQ: begin
                                v_acc = 16'd0; v_phase = PH_BNUM;
                            end
                            PH_BNUM: begin
                                if (is_dig) begin
                                    v_acc = acc_push(v_acc, c[3:0]);
                                end else begin
                                    b_dsr     = v_acc;
                                    v_bz      = (v_acc == 16'd0);
                                    need_bdiv = (v_acc != 16'd0);
                                    v_whole   = 18'd0;
                                    v_acc = 16'd0; v_pitch = 4'd0; v_dot = 1'b0;
                                    v_oct = OCT_NONE;
                                    v_phase = PH_NDUR;
                                end
                            end
                            PH_NDUR: begin
                                if (is_dig) begin
                                    v_acc = acc_push(v_acc, c[3:0]);
                                end else begin
                                    v_pitch = letter_step(c); v_phase = PH_NSHARP;
                                end
                            end
                            PH_NSHARP, PH_NDOT, PH_NOCT, PH_NEND: begin
                                if (c == CH_COMMA) begin
                                    emit_c = 1'b1;
                                    v_acc = 16'd0; v_pitch = 4'd0; v_dot = 1'b0;
                                    v_oct = OCT_NONE;
                                    v_phase = PH_NDUR;
                                end else if (c == CH_HASH && v_phase == PH_NSHARP) begin
                                    v_pitch = v_pitch + 4'd1; v_phase = PH_NDOT;
                                end else if (c == CH_DOT &&
                                             (v_phase == PH_NSHARP || v_phase == PH_NDOT)) begin
                                    v_dot = 1'b1; v_phase = PH_NOCT;
                                end else if (is_dig && v_phase != PH_NEND) begin
                                    v_oct = c[3:0]; v_phase = PH_NEND;
                                end
                            end
                            PH_NAME: begin
                                if (c == CH_COLON) v_phase = PH_KEY;
                            end
                            default: begin
                                v_phase = (c == CH_COLON) ? PH_KEY : PH_NAME;
                            end
                        endcase
                    end

                    emit_l = i_item.last && !emit_c &&
                             (v_phase >= PH_NDUR) && (v_phase <= PH_NEND);

                    // note fields: before the clear on a comma, after the update otherwise
                    if (emit_c) begin
                        s_acc = r_acc; s_pitch = r_pitch; s_dot = r_dot; s_oct = r_oct;
                    end else begin
                        s_acc = v_acc; s_pitch = v_pitch; s_dot = v_dot; s_oct = v_oct;
                    end
                    e_div     = (s_acc != 16'd0) ? s_acc : v_dlen;
                    bad0      = v_bz || (e_div == 16'd0);
                    scale     = (s_oct == OCT_NONE) ? {1'b0, v_doct} : s_oct;
                    sum       = {1'b0, scale, 3'b000} + {2'b00, scale, 2'b00}
                              + {4'd0, s_pitch};
                    range_bad = (sum < IDX_BASE) || (sum > IDX_TOP);
                    idx       = sum - IDX_BASE;

                    n_phase = v_phase; n_dlen = v_dlen; n_doct = v_doct;
                    n_whole = v_whole; n_acc = v_acc; n_pitch = v_pitch;
                    n_dot = v_dot; n_oct = v_oct; n_bz = v_bz;

                    n_e_div  = e_div;
                    n_e_skip = bad0;
                    n_e_rest = (s_pitch == 4'd0);
                    n_e_bad  = bad0 || ((s_pitch != 4'd0) && range_bad);
                    n_e_freq = ((s_pitch != 4'd0) && !bad0 && !range_bad) ?
                               freq_lookup(idx[5:0]) : 12'd0;
                    // a dotted note adds half; kept for the finishing state
                    n_dot_snap  = s_dot;
                    n_job_bpm   = need_bdiv;
                    n_pend_emit = emit_c || emit_l;
                    n_pend_last = i_item.last;
                    n_rem       = 16'd0;
                    n_cnt       = DIV_LAST;

                    if (need_bdiv) begin
                        n_seq = S_DIV; n_dq = BPM_NUM; n_dsr = b_dsr;
                    end else if (emit_c || emit_l) begin
                        n_dq  = v_whole; n_dsr = e_div;
                        n_seq = bad0 ? S_FIN : S_DIV;
                    end else if (i_item.last) begin
                        do_reset = 1'b1;
                    end
                end
            end
            S_DIV: begin
                n_rem = ge ? t_diff[15:0] : t_part[15:0];
                n_dq  = q_new;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    if (r_job_bpm) begin
                        n_whole   = {q_new[15:0], 2'b00};
                        n_job_bpm = 1'b0;
                        if (!r_pend_emit) begin
                            n_seq = S_IDLE;
                        end else if (r_e_skip) begin
                            n_seq = S_FIN;
                        end else begin
                            n_dq  = {q_new[15:0], 2'b00};
                            n_dsr = r_e_div;
                            n_rem = 16'd0;
                            n_cnt = DIV_LAST;
                        end
                    end else begin
                        n_seq = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.freq_hz = r_e_freq;
                    n_out.dur_ms  = r_e_skip ? 19'd0 :
                                    (r_dot_snap ? ({1'b0, r_dq} + {2'b00, r_dq[17:1]})
                                                : {1'b0, r_dq});
                    n_out.is_rest = r_e_rest;
                    n_out.bad     = r_e_bad;
                    n_out_valid   = 1'b1;
                    do_reset      = r_pend_last;
                    n_seq         = S_IDLE;
                end
            end
            default: n_seq = S_IDLE;
        endcase

        if (do_reset) begin
            n_phase = PH_NAME; n_dlen = DLEN_RST; n_doct = DOCT_RST;
            n_whole = 18'd0; n_bz = 1'b0;
            n_acc = 16'd0; n_pitch = 4'd0; n_dot = 1'b0; n_oct = OCT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase     <= PH_NAME;
            r_dlen      <= DLEN_RST;
            r_doct      <= DOCT_RST;
            r_whole     <= 18'd0;
            r_acc       <= 16'd0;
            r_pitch     <= 4'd0;
            r_dot       <= 1'b0;
            r_oct       <= OCT_NONE;
            r_bz        <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_dlen      <= n_dlen;
            r_doct      <= n_doct;
            r_whole     <= n_whole;
            r_acc       <= n_acc;
            r_pitch     <= n_pitch;
            r_dot       <= n_dot;
            r_oct       <= n_oct;
            r_bz        <= n_bz;
        end
        r_job_bpm   <= n_job_bpm;
        r_pend_emit <= n_pend_emit;
        r_pend_last <= n_pend_last;
        r_cnt       <= n_cnt;
        r_dq        <= n_dq;
        r_rem       <= n_rem;
        r_dsr       <= n_dsr;
        r_e_freq    <= n_e_freq;
        r_e_bad     <= n_e_bad;
        r_e_rest    <= n_e_rest;
        r_e_skip    <= n_e_skip;
        r_e_div     <= n_e_div;
        r_dot_snap  <= n_dot_snap;
        r_out       <= n_out;
    end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTTTL note parser testbench
// Feeds ringtone characters through the parser and checks every note it
// emits against a cycle-free parsing model kept in step with accepted items.
// ----------------------------------------------------------------------------
module tb;
    import rtttl_pkg::*;

    typedef enum logic [3:0] {
        P_NAME, P_KEY, P_DEQ, P_DNUM, P_OEQ, P_ODIG, P_OSKIP, P_BEQ, P_BNUM,
        P_NDUR, P_NSHARP, P_NDOT, P_NOCT, P_NEND
    } t_phase;

    typedef struct packed {
        t_in_item   it;
        logic       hold;
        logic [1:0] pace;
    } t_pending;

    localparam logic [1:0] PACE_A    = 2'd0;   // fast sender, busy receiver
    localparam logic [1:0] PACE_B    = 2'd1;   // the other way round
    localparam logic [1:0] PACE_FREE = 2'd2;
    localparam int IDLE_LO      = 29;
    localparam int IDLE_HI      = 81;
    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 64;
    localparam int TONE_TOP     = 48;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      chr_valid = 1'b0;
    logic      chr_stall;
    t_in_item  chr_item = '0;
    logic      note_valid;
    logic      note_stall = 1'b0;
    t_out_item note_res;

    t_pending    pend [$];
    t_out_item   notes_due [$];
    logic [7:0]  tune_buf [$];
    logic [1:0]  cur_pace = PACE_A;
    logic        notes_clear = 1'b1;
    bit          failed = 0;
    int          quiet = 0;

    // parser model state
    t_phase      ph;
    logic [15:0] dflt_len;
    logic [2:0]  dflt_oct;
    logic [17:0] whole_ms;
    logic [15:0] acc;
    logic [3:0]  pstep;
    bit          dotted;
    logic [3:0]  oct_dig;
    bit          bpm_zero;

    logic [11:0] tone_hz [0:48] = '{
        12'd0,
        12'd262,  12'd277,  12'd294,  12'd311,  12'd330,  12'd349,
        12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494,
        12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,
        12'd740,  12'd784,  12'd831,  12'd880,  12'd932,  12'd988,
        12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
        12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976,
        12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
        12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951
    };

    rtttl_note_parser_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (chr_valid),
        .o_stall (chr_stall),
        .i_item  (chr_item),
        .o_valid (note_valid),
        .i_stall (note_stall),
        .o_res   (note_res)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // parsing model
    // ------------------------------------------------------------------
    task clear_note();
        acc     = '0;
        pstep   = '0;
        dotted  = 0;
        oct_dig = OCT_NONE;
    endtask

    task tune_reset();
        ph       = P_NAME;
        dflt_len = DLEN_RST;
        dflt_oct = DOCT_RST;
        whole_ms = '0;
        bpm_zero = 0;
        clear_note();
    endtask

    function automatic logic [15:0] add_digit(input logic [15:0] a, input logic [7:0] c);
        int v;
        v = a * 10 + (c - CH_ZERO);
        return (v > ACC_MAX) ? ACC_MAX : v[15:0];
    endfunction

    function automatic logic [3:0] step_of(input logic [7:0] c);
        case (c)
            "c":     return 4'd1;
            "d":     return 4'd3;
            "e":     return 4'd5;
            "f":     return 4'd6;
            "g":     return 4'd8;
            "a":     return 4'd10;
            "b":     return 4'd12;
            default: return 4'd0;
        endcase
    endfunction

    function automatic t_out_item close_note();
        logic [15:0] div;
        bit          bad;
        int unsigned dur;
        int          scale;
        int          idx;
        t_out_item   r;
        r   = '0;
        dur = 0;
        div = (acc != 0) ? acc : dflt_len;
        bad = bpm_zero || div == 0;
        if (!bad) begin
            dur = whole_ms / div;
            if (dotted) dur = dur + dur / 2;
        end
        scale = (oct_dig == OCT_NONE) ? int'(dflt_oct) : int'(oct_dig);
        if (pstep != 0 && !bad) begin
            idx = scale * 12 + int'(pstep) - int'(IDX_BASE);
            if (idx < 0 || idx > TONE_TOP) bad = 1;
            else r.freq_hz = tone_hz[idx];
        end
        r.dur_ms  = dur[18:0];
        r.is_rest = (pstep == 0);
        r.bad     = bad;
        return r;
    endfunction

    task automatic parse_char(input t_in_item it, output bit emitted, output t_out_item note);
        logic [7:0] c;
        bit         is_digit;
        bit         at_key;
        c        = it.ch;
        emitted  = 0;
        note     = '0;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        at_key   = (ph == P_KEY);
        if (at_key) begin
            if (c == CH_KEY_D) ph = P_DEQ;
            else if (c == CH_KEY_O) ph = P_OEQ;
            else if (c == CH_KEY_B) ph = P_BEQ;
            else begin
                // no more keys: notes start on this very character
                whole_ms = WHOLE_DFLT;
                bpm_zero = 0;
                clear_note();
                ph = P_NDUR;
            end
        end
        if (!at_key || ph == P_NDUR) begin
            case (ph)
                P_DEQ: begin
                    acc = '0;
                    ph  = P_DNUM;
                end
                P_DNUM: begin
                    if (is_digit) acc = add_digit(acc, c);
                    else begin
                        if (acc != 0) dflt_len = acc;
                        acc = '0;
                        ph  = P_KEY;
                    end
                end
                P_OEQ: ph = P_ODIG;
                P_ODIG: begin
                    if (c >= CH_THREE && c <= CH_SEVEN) dflt_oct = c[2:0];
                    ph = P_OSKIP;
                end
                P_OSKIP: ph = P_KEY;
                P_BEQ: begin
                    acc = '0;
                    ph  = P_BNUM;
                end
                P_BNUM: begin
                    if (is_digit) acc = add_digit(acc, c);
                    else begin
                        bpm_zero = (acc == 0);
                        whole_ms = bpm_zero ? '0 : 18'((BPM_NUM / acc) * 4);
                        clear_note();
                        ph = P_NDUR;
                    end
                end
                P_NDUR: begin
                    if (is_digit) acc = add_digit(acc, c);
                    else begin
                        pstep = step_of(c);
                        ph    = P_NSHARP;
                    end
                end
                P_NSHARP, P_NDOT, P_NOCT, P_NEND: begin
                    if (c == CH_COMMA) begin
                        note    = close_note();
                        emitted = 1;
                        clear_note();
                        ph = P_NDUR;
                    end else if (c == CH_HASH && ph == P_NSHARP) begin
                        pstep = pstep + 4'd1;
                        ph    = P_NDOT;
                    end else if (c == CH_DOT && (ph == P_NSHARP || ph == P_NDOT)) begin
                        dotted = 1;
                        ph     = P_NOCT;
                    end else if (is_digit && ph != P_NEND) begin
                        oct_dig = c[3:0];
                        ph      = P_NEND;
                    end
                end
                default: ph = (c == CH_COLON) ? P_KEY : P_NAME;
            endcase
        end
        if (it.last) begin
            if (!emitted && ph >= P_NDUR && ph <= P_NEND) begin
                note    = close_note();
                emitted = 1;
            end
            tune_reset();
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic put_str(input string s);
        for (int k = 0; k < s.len(); k++) tune_buf.push_back(s[k]);
    endtask

    function automatic int pick_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 99999);
        return 1 << $urandom_range(0, 5);
    endfunction

    function automatic logic [7:0] pick_octave();
        if ($urandom_range(0, 3) != 0) return 8'(CH_THREE + $urandom_range(1, 4));
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic send_tune(input int stop, input bit with_last, input logic [1:0] pace,
                             input bit hold);
        t_pending p;
        for (int k = 0; k <= stop; k++) begin
            p.it.ch   = tune_buf[k];
            p.it.last = with_last && k == stop;
            p.hold    = hold && k == 0;
            p.pace    = pace;
            pend.push_back(p);
        end
        tune_buf.delete();
    endtask

    task automatic make_tune();
        string letters;
        int    swap;
        int    notes;
        int    r;
        letters = "cdefgabp";
        repeat ($urandom_range(0, 6)) tune_buf.push_back(8'($urandom_range(0, 255)));
        tune_buf.push_back(CH_COLON);
        swap = $urandom_range(0, 1);
        for (int k = 0; k < 2; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                if ((k ^ swap) == 0) begin
                    put_str("d=");
                    put_str($sformatf("%0d", pick_len()));
                end else begin
                    put_str("o=");
                    tune_buf.push_back(pick_octave());
                end
                tune_buf.push_back(CH_COMMA);
            end
        end
        if ($urandom_range(0, 7) != 0) begin
            r = $urandom_range(0, 15);
            put_str("b=");
            if (r == 0) put_str("0");
            else if (r == 1) put_str("1");
            else if (r == 2) put_str($sformatf("%0d", $urandom_range(65536, 999999)));
            else put_str($sformatf("%0d", $urandom_range(25, 400)));
            tune_buf.push_back($urandom_range(0, 1) ? CH_COLON : CH_COMMA);
        end else begin
            tune_buf.push_back(CH_COLON);
        end
        notes = $urandom_range(1, 10);
        for (int k = 0; k < notes; k++) begin
            if ($urandom_range(0, 9) != 0) put_str($sformatf("%0d", pick_len()));
            if ($urandom_range(0, 7) != 0) tune_buf.push_back(letters[$urandom_range(0, 7)]);
            else tune_buf.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 2) == 0) tune_buf.push_back(CH_HASH);
            if ($urandom_range(0, 3) == 0) tune_buf.push_back(CH_DOT);
            if ($urandom_range(0, 2) != 0) tune_buf.push_back(pick_octave());
            if ($urandom_range(0, 19) == 0) tune_buf.push_back(8'($urandom_range(0, 255)));
            if (k != notes - 1) tune_buf.push_back(CH_COMMA);
        end
    endtask

    // ------------------------------------------------------------------
    // driver, receiver stalls and monitor
    // ------------------------------------------------------------------
    always @(posedge clk) begin : driver
        int idle_pct;
        if (!rst_n) begin
            chr_valid <= 1'b0;
        end else if (!chr_valid || !chr_stall) begin
            idle_pct = 0;
            if (pend.size() != 0)
                idle_pct = (pend[0].pace == PACE_A) ? IDLE_LO :
                           (pend[0].pace == PACE_B) ? IDLE_HI : 0;
            // a held item waits for every outstanding note to drain
            if (pend.size() != 0 && (!pend[0].hold || (!chr_valid && notes_clear))
                    && $urandom_range(0, 99) >= idle_pct) begin
                chr_item  <= pend[0].it;
                cur_pace  <= pend[0].pace;
                chr_valid <= 1'b1;
                pend.delete(0);
            end else begin
                chr_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            note_stall <= 1'b0;
        end else begin
            note_stall <= $urandom_range(0, 99) < ((cur_pace == PACE_A) ? IDLE_HI :
                                                  (cur_pace == PACE_B) ? IDLE_LO : 0);
        end
    end

    always @(posedge clk) begin : monitor
        t_out_item fresh;
        t_out_item want;
        bit        made;
        if (rst_n) begin
            if (chr_valid && !chr_stall) begin
                parse_char(chr_item, made, fresh);
                if (made) notes_due.push_back(fresh);
            end
            if (note_valid && !note_stall) begin
                if (notes_due.size() == 0) begin
                    $error("unexpected note: freq_hz %0d dur_ms %0d",
                           note_res.freq_hz, note_res.dur_ms);
                    failed = 1;
                end else begin
                    want = notes_due.pop_front();
                    if (note_res.freq_hz !== want.freq_hz) begin
                        $error("freq_hz: expected %0d, got %0d", want.freq_hz, note_res.freq_hz);
                        failed = 1;
                    end
                    if (note_res.dur_ms !== want.dur_ms) begin
                        $error("dur_ms: expected %0d, got %0d", want.dur_ms, note_res.dur_ms);
                        failed = 1;
                    end
                    if (note_res.is_rest !== want.is_rest) begin
                        $error("is_rest: expected %0b, got %0b", want.is_rest, note_res.is_rest);
                        failed = 1;
                    end
                    if (note_res.bad !== want.bad) begin
                        $error("bad: expected %0b, got %0b", want.bad, note_res.bad);
                        failed = 1;
                    end
                end
            end
            if ((chr_valid && !chr_stall) || (note_valid && !note_stall)) quiet = 0;
            else quiet = quiet + 1;
        end
        notes_clear <= (notes_due.size() == 0);
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin : sequence_run
        int         directed_n;
        int         r;
        logic [1:0] pace;
        logic [1:0] prev_pace;
        tune_reset();

        // zero bpm, a comma read as the letter, note closed by last
        tune_buf.push_back(8'hFF);
        put_str(":b=0,,");
        send_tune(tune_buf.size() - 1, 1, PACE_A, 0);
        // low octave key, saturating duration digits, sharp rest,
        // index above the table, stray characters, last inside a note
        tune_buf.push_back(8'h00);
        put_str(":o=3,b=240,99999p#6,b#.9.#");
        send_tune(tune_buf.size() - 1, 1, PACE_A, 0);
        // longest note: one bpm, whole length, dotted
        put_str(":d=1,b=1,b.");
        send_tune(tune_buf.size() - 1, 1, PACE_A, 0);
        directed_n = pend.size();

        prev_pace = PACE_A;
        while (pend.size() < directed_n + RANDOM_ITEMS) begin
            pace = 2'(((pend.size() - directed_n) * 3) / RANDOM_ITEMS);
            make_tune();
            r = $urandom_range(0, 19);
            send_tune((r < 2) ? $urandom_range(0, tune_buf.size() - 1) : tune_buf.size() - 1,
                      r != 2, pace, pace != prev_pace || $urandom_range(0, 9) == 0);
            prev_pace = pace;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while ((pend.size() != 0 || chr_valid || notes_due.size() != 0) && quiet < QUIET_LIMIT)
            @(negedge clk);
        if (quiet < QUIET_LIMIT) repeat (TAIL_CYCLES) @(negedge clk);
        if (quiet >= QUIET_LIMIT) failed = 1;
        if (!failed) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

// ===== rtttl_note_parser_unit.f =====
rtl/rtttl_pkg.sv
rtl/rtttl_note_parser_unit.sv
tb/tb.sv
